FILE: sv/tbwl_pkg.sv
// Package: shared types and constants of the token bucket rate limiter.
package tbwl_pkg;

  localparam int RPM_W   = 13;
  localparam int OPS_W   = 8;
  localparam int FRAC_W  = 16;
  localparam int ELAP_W  = 10;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  localparam logic [FRAC_W-1:0] UNITS_PER_TOKEN = 16'd60000;
  localparam logic [ELAP_W-1:0] WINDOW_MS       = 10'd1000;
  localparam logic [OPS_W-1:0]  COUNT_MAX       = 8'd255;

  localparam logic [RPM_W-1:0] RPM_RESET = 13'd1200;
  localparam logic [OPS_W-1:0] OPS_RESET = 8'd10;

  localparam logic [CFG_IDX_W-1:0] CFG_RPM = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OPS = 2'd1;

  localparam logic ACT_TICK    = 1'b0;
  localparam logic ACT_REQUEST = 1'b1;

  typedef struct packed {
    logic action;
    logic is_order;
  } item_t;

  // Per-transaction control into the state modules
  typedef struct packed {
    logic  step;     // item in the input stage is being processed
    item_t item;
    logic  grant;    // final grant decision
  } step_ctl_t;

  typedef struct packed {
    logic              granted;
    logic [RPM_W-1:0]  whole_tokens;
    logic [OPS_W-1:0]  orders_in_window;
  } result_t;

endpackage

FILE: sv/tbwl_if.sv
// Interfaces: request channel and result channel of the rate limiter.
interface tbwl_item_if;
  logic valid;
  logic ready;
  logic action;
  logic is_order;
  modport source (output valid, output action, output is_order, input ready);
  modport sink   (input valid, input action, input is_order, output ready);
endinterface

interface tbwl_result_if import tbwl_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             granted;
  logic [RPM_W-1:0] whole_tokens;
  logic [OPS_W-1:0] orders_in_window;
  modport source (output valid, output granted, output whole_tokens,
                  output orders_in_window, input ready);
  modport sink   (input valid, input granted, input whole_tokens,
                  input orders_in_window, output ready);
endinterface

FILE: sv/token_bucket_with_burst_limit.sv
// Top level: token bucket rate limiter with per-window order burst limit.
//
//   channel  dir  handshake     payload
//   item     in   valid/ready   action, is_order
//   result   out  valid/ready   granted, whole_tokens, orders_in_window
//   cfg      in   cfg_we        cfg_index, cfg_data (no ready, no read-back)
//
// One transaction per cycle sustained while the result port is ready; an
// accepted item is held in the input register, then its result in the result
// register. All state updates for an item happen in the single cycle it
// leaves the input register. rst is synchronous, active high; it restores
// the register defaults, a full bucket and an empty window. A stalled result
// register back-pressures the input register, which then back-pressures the
// item port.
module token_bucket_with_burst_limit import tbwl_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  tbwl_item_if.sink             item,
  tbwl_result_if.source         result
);

  // Configuration registers
  logic [RPM_W-1:0] requests_per_minute;
  logic [OPS_W-1:0] orders_per_second;

  always_ff @(posedge clk) begin
    if (rst) begin
      requests_per_minute <= RPM_RESET;
      orders_per_second   <= OPS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_RPM: requests_per_minute <= cfg_data[RPM_W-1:0];
        CFG_OPS: orders_per_second   <= cfg_data[OPS_W-1:0];
        default: ;
      endcase
    end
  end

  // Input register
  logic  in_valid;
  item_t in_item;
  // Result register
  logic    out_valid;
  result_t out_data;

  logic advance;   // result register can take a new value this cycle
  assign advance    = !out_valid || result.ready;
  assign item.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst)
      in_valid <= 1'b0;
    else if (item.ready)
      in_valid <= item.valid;
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      in_item.action   <= item.action;
      in_item.is_order <= item.is_order;
    end
  end

  // Decision for the item in the input register
  step_ctl_t        ctl;
  logic             token_ok;
  logic             burst_ok;
  logic [RPM_W-1:0] whole_tokens_next;
  logic [OPS_W-1:0] count_next;

  always_comb begin
    ctl.step  = in_valid && advance;
    ctl.item  = in_item;
    // Ticks are never granted; a request needs a whole token and burst room
    ctl.grant = (in_item.action == ACT_REQUEST) && token_ok && burst_ok;
  end

  tbwl_bucket u_bucket (
    .clk                 (clk),
    .rst                 (rst),
    .requests_per_minute (requests_per_minute),
    .ctl                 (ctl),
    .token_ok            (token_ok),
    .whole_tokens_next   (whole_tokens_next)
  );

  tbwl_window u_window (
    .clk               (clk),
    .rst               (rst),
    .orders_per_second (orders_per_second),
    .ctl               (ctl),
    .burst_ok          (burst_ok),
    .count_next        (count_next)
  );

  always_ff @(posedge clk) begin
    if (rst)
      out_valid <= 1'b0;
    else if (advance)
      out_valid <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (ctl.step) begin
      out_data.granted          <= ctl.grant;
      out_data.whole_tokens     <= whole_tokens_next;
      out_data.orders_in_window <= count_next;
    end
  end

  assign result.valid            = out_valid;
  assign result.granted          = out_data.granted;
  assign result.whole_tokens     = out_data.whole_tokens;
  assign result.orders_in_window = out_data.orders_in_window;

endmodule

FILE: sv/tbwl_bucket.sv
// Token bucket and refill accumulator, kept as whole tokens plus a fraction.
module tbwl_bucket import tbwl_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic [RPM_W-1:0] requests_per_minute,
  input  step_ctl_t        ctl,
  output logic             token_ok,
  output logic [RPM_W-1:0] whole_tokens_next
);

  logic [RPM_W-1:0]  bucket_tok, bucket_tok_next;
  logic [FRAC_W-1:0] bucket_frac, bucket_frac_next;
  logic [RPM_W-1:0]  acc_tok, acc_tok_next;
  logic [FRAC_W-1:0] acc_frac, acc_frac_next;

  logic [FRAC_W:0]   tick_f;
  logic [FRAC_W-1:0] tick_f2;
  logic              tick_c;
  logic [RPM_W:0]    tick_t;
  logic              tick_over;

  logic [FRAC_W:0]   sum_f;
  logic [FRAC_W-1:0] sum_f2;
  logic              sum_c;
  logic [RPM_W+1:0]  sum_t;
  logic              sum_over;
  logic              do_refill;
  logic [RPM_W-1:0]  ref_tok;
  logic [FRAC_W-1:0] ref_frac;

  // Tick: accumulator plus one millisecond of refill, clamped to capacity
  always_comb begin
    tick_f  = {1'b0, acc_frac} + {{(FRAC_W+1-RPM_W){1'b0}}, requests_per_minute};
    tick_c  = (tick_f >= {1'b0, UNITS_PER_TOKEN});
    tick_f2 = tick_c ? FRAC_W'(tick_f - {1'b0, UNITS_PER_TOKEN}) : tick_f[FRAC_W-1:0];
    tick_t  = {1'b0, acc_tok} + {{RPM_W{1'b0}}, tick_c};
    tick_over = (tick_t > {1'b0, requests_per_minute}) ||
                ((tick_t == {1'b0, requests_per_minute}) && (tick_f2 != '0));
  end

  // Request: move accumulator into bucket when worth a whole token
  always_comb begin
    sum_f  = {1'b0, bucket_frac} + {1'b0, acc_frac};
    sum_c  = (sum_f >= {1'b0, UNITS_PER_TOKEN});
    sum_f2 = sum_c ? FRAC_W'(sum_f - {1'b0, UNITS_PER_TOKEN}) : sum_f[FRAC_W-1:0];
    sum_t  = {2'b00, bucket_tok} + {2'b00, acc_tok} + {{(RPM_W+1){1'b0}}, sum_c};
    sum_over = (sum_t > {2'b00, requests_per_minute}) ||
               ((sum_t == {2'b00, requests_per_minute}) && (sum_f2 != '0));
    do_refill = (acc_tok != '0);
    if (!do_refill) begin
      ref_tok  = bucket_tok;
      ref_frac = bucket_frac;
    end else if (sum_over) begin
      ref_tok  = requests_per_minute;
      ref_frac = '0;
    end else begin
      ref_tok  = sum_t[RPM_W-1:0];
      ref_frac = sum_f2;
    end
    token_ok = (ref_tok != '0);
  end

  always_comb begin
    bucket_tok_next  = bucket_tok;
    bucket_frac_next = bucket_frac;
    acc_tok_next     = acc_tok;
    acc_frac_next    = acc_frac;
    if (ctl.item.action == ACT_TICK) begin
      if (tick_over) begin
        acc_tok_next  = requests_per_minute;
        acc_frac_next = '0;
      end else begin
        acc_tok_next  = tick_t[RPM_W-1:0];
        acc_frac_next = tick_f2;
      end
    end else begin
      bucket_frac_next = ref_frac;
      bucket_tok_next  = ctl.grant ? (ref_tok - 1'b1) : ref_tok;
      if (do_refill) begin
        acc_tok_next  = '0;
        acc_frac_next = '0;
      end
    end
    whole_tokens_next = bucket_tok_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bucket_tok  <= RPM_RESET;
      bucket_frac <= '0;
      acc_tok     <= '0;
      acc_frac    <= '0;
    end else if (ctl.step) begin
      bucket_tok  <= bucket_tok_next;
      bucket_frac <= bucket_frac_next;
      acc_tok     <= acc_tok_next;
      acc_frac    <= acc_frac_next;
    end
  end

endmodule

FILE: sv/tbwl_window.sv
// Order burst window: elapsed-time counter and granted-order count.
module tbwl_window import tbwl_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic [OPS_W-1:0] orders_per_second,
  input  step_ctl_t        ctl,
  output logic             burst_ok,
  output logic [OPS_W-1:0] count_next
);

  logic [ELAP_W-1:0] window_elapsed_ms, window_elapsed_ms_next;
  logic [OPS_W-1:0]  window_order_count;
  logic [OPS_W-1:0]  count_eff;
  logic              restart;

  always_comb begin
    restart   = (ctl.item.action == ACT_REQUEST) && ctl.item.is_order &&
                (window_elapsed_ms >= WINDOW_MS);
    count_eff = restart ? '0 : window_order_count;
    burst_ok  = !ctl.item.is_order || (count_eff < orders_per_second);

    window_elapsed_ms_next = window_elapsed_ms;
    count_next             = window_order_count;
    if (ctl.item.action == ACT_TICK) begin
      if (window_elapsed_ms < WINDOW_MS)
        window_elapsed_ms_next = window_elapsed_ms + 1'b1;
    end else begin
      if (restart)
        window_elapsed_ms_next = '0;
      count_next = count_eff;
      if (ctl.grant && ctl.item.is_order && (count_eff < COUNT_MAX))
        count_next = count_eff + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_elapsed_ms  <= '0;
      window_order_count <= '0;
    end else if (ctl.step) begin
      window_elapsed_ms  <= window_elapsed_ms_next;
      window_order_count <= count_next;
    end
  end

endmodule
